// File: sv/cds_pkg.sv
// Package for the dominator-set block: types, commands and sizing constants.
// No dependencies; used by the top level and the testbench.
`default_nettype none
package cds_pkg;
   localparam int MaxBlocks = 32;
   localparam int IdxW = 5;
   localparam int SetW = 32;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_COMPUTE = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [4:0] src_block;
      logic [4:0] dst_block;
   } req_type;

   typedef struct packed {
      logic [4:0]  block_id;
      logic [31:0] dominator_mask;
      logic [4:0]  idom_block;
      logic        idom_valid;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

// File: sv/cds_ram.sv
// Generic single-port-write, one-read RAM with a registered read.
// No dependencies.
`default_nettype none
module cds_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: sv/cfg_dominator_sets.sv
// Top level of the dominator-set block: sequencer, predecessor RAM and set RAM.
// Depends on cds_pkg and cds_ram.
//
//   channel | direction | handshake     | beat
//   req     | in        | valid / ready | cmd, src_block, dst_block
//   rsp     | out       | valid / ready | one result per block
//   csr     | in        | write enable  | block_count
//
// An edge add reads the row and then writes it back. A clear sweeps the
// 32 rows of the predecessor RAM, one a cycle. A compute runs passes of
// the fixpoint; for every block of a pass, each predecessor costs a
// search step (none when it is block 0) and one read of the set RAM. The
// emit phase then scans for the immediate dominator of each block and
// waits on rsp_ready as needed. Reset clears control state only; the
// predecessor RAM is cleared by a sweep after reset, during which req_ready
// stays low.
`default_nettype none
module cfg_dominator_sets (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cds_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output cds_pkg::rsp_type       rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [5:0]        csr_wr_data
);
   import cds_pkg::*;

   typedef enum logic [10:0] {
      ST_CLEAR   = 11'b00000000001,
      ST_IDLE    = 11'b00000000010,
      ST_ADDWR   = 11'b00000000100,
      ST_PRDRD   = 11'b00000001000,
      ST_PRDWT   = 11'b00000010000,
      ST_MEET    = 11'b00000100000,
      ST_MEETWT  = 11'b00001000000,
      ST_EMRD    = 11'b00010000000,
      ST_EMSCAN  = 11'b00100000000,
      ST_EMSCWT  = 11'b01000000000,
      ST_EMOUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [5:0]      count_ff;
   logic [IdxW-1:0] blk_ff, blk_in;
   logic [IdxW-1:0] p_ff, p_in;
   logic [5:0]      clr_ff, clr_in;
   logic [SetW-1:0] preds_ff, preds_in;
   logic [SetW-1:0] meet_ff, meet_in;
   logic [SetW-1:0] own_ff, own_in;
   logic            changed_ff, changed_in;
   logic            fwd_ff, fwd_in;
   logic [IdxW-1:0] idom_ff, idom_in;
   logic            found_ff, found_in;
   req_type         req_ff, req_in;
   logic            rvalid_ff, rvalid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            p_we, d_we;
   logic [IdxW-1:0] p_wa, p_ra, d_wa, d_ra;
   logic [SetW-1:0] p_wd, p_rd, d_wd, d_rd;

   logic [5:0]      n_act;
   logic [SetW-1:0] full;
   logic [SetW-1:0] strict;
   logic [SetW-1:0] nxt;
   logic [5:0]      nxt_p;
   logic [IdxW-1:0] last_blk;

   cds_ram #(.Width(SetW), .Depth(MaxBlocks)) u_pred (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));
   cds_ram #(.Width(SetW), .Depth(MaxBlocks)) u_dom (
      .clock(clock), .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(d_ra), .rd_data(d_rd));

   // Active count and its full mask.
   always_comb begin
      n_act = (count_ff == 6'd0) ? 6'd1 : ((count_ff > 6'd32) ? 6'd32 : count_ff);
      full = (n_act == 6'd32) ? '1 : ((SetW'(1) << n_act) - SetW'(1));
      last_blk = IdxW'(n_act - 6'd1);
   end

   // Next remaining predecessor above p_ff (search over preds_ff).
   always_comb begin
      nxt_p = 6'd32;
      for (int i = SetW - 1; i >= 0; i--) begin
         if (preds_ff[i] && (6'(i) > {1'b0, p_ff})) begin
            nxt_p = 6'(i);
         end
      end
   end

   assign strict = own_ff & ~(SetW'(1) << blk_ff) & full;
   assign nxt = meet_ff | (SetW'(1) << blk_ff);

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 6'd1;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      blk_in = blk_ff;
      p_in = p_ff;
      clr_in = clr_ff;
      preds_in = preds_ff;
      meet_in = meet_ff;
      own_in = own_ff;
      changed_in = changed_ff;
      fwd_in = 1'b0;
      idom_in = idom_ff;
      found_in = found_ff;
      req_in = req_ff;
      rvalid_in = rvalid_ff;
      rsp_in = rsp_ff;
      p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
      d_we = 1'b0; d_wa = '0; d_wd = '0; d_ra = '0;
      req_ready = 1'b0;
      if (rvalid_ff && rsp_ready) begin
         rvalid_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            p_we = 1'b1;
            p_wa = clr_ff[IdxW-1:0];
            if (clr_ff == 6'd31) begin
               state_in = ST_IDLE;
            end
            clr_in = clr_ff + 6'd1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            p_ra = req_data.dst_block;
            if (req_valid) begin
               req_in = req_data;
               case (req_data.cmd)
                  CMD_ADD: state_in = ST_ADDWR;
                  CMD_CLEAR: begin
                     clr_in = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_COMPUTE: begin
                     // Seed the entry set to {0}; the other sets follow in ST_PRDRD.
                     d_we = 1'b1;
                     d_wa = '0;
                     d_wd = SetW'(1);
                     clr_in = 6'd1;
                     state_in = ST_PRDRD;
                     blk_in = '0;
                     changed_in = 1'b0;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADDWR: begin
            p_we = 1'b1;
            p_wa = req_ff.dst_block;
            p_wd = p_rd | (SetW'(1) << req_ff.src_block);
            state_in = ST_IDLE;
         end
         ST_PRDRD: begin
            // Finish seeding first, then start a pass at block 1, or emit when only one block is active.
            if (clr_ff < n_act) begin
               d_we = 1'b1;
               d_wa = clr_ff[IdxW-1:0];
               d_wd = full;
               clr_in = clr_ff + 6'd1;
            end else if (n_act == 6'd1) begin
               blk_in = '0;
               state_in = ST_EMRD;
            end else begin
               blk_in = IdxW'(1);
               changed_in = 1'b0;
               p_ra = IdxW'(1);
               d_ra = IdxW'(1);
               state_in = ST_PRDWT;
            end
         end
         ST_PRDWT: begin
            preds_in = p_rd & full;
            meet_in = full;
            p_in = '0;
            state_in = ST_MEET;
         end
         ST_MEET: begin
            // Issue the read of the next predecessor's set.
            if (preds_ff[p_ff]) begin
               d_ra = p_ff;
               state_in = ST_MEETWT;
            end else if (nxt_p != 6'd32) begin
               p_in = nxt_p[IdxW-1:0];
            end else begin
               // Block done: write back and move on.
               if (nxt != own_ff) begin
                  changed_in = 1'b1;
               end
               d_we = 1'b1;
               d_wa = blk_ff;
               d_wd = nxt;
               if (blk_ff == last_blk) begin
                  if ((nxt != own_ff) || changed_ff) begin
                     blk_in = IdxW'(1);
                     changed_in = 1'b0;
                     p_ra = IdxW'(1);
                     d_ra = IdxW'(1);
                     // With two blocks the set just written is the one read back.
                     fwd_in = (blk_ff == IdxW'(1));
                     state_in = ST_PRDWT;
                  end else begin
                     blk_in = '0;
                     state_in = ST_EMRD;
                  end
               end else begin
                  blk_in = blk_ff + IdxW'(1);
                  p_ra = blk_ff + IdxW'(1);
                  d_ra = blk_ff + IdxW'(1);
                  state_in = ST_PRDWT;
               end
            end
         end
         ST_MEETWT: begin
            meet_in = meet_ff & d_rd;
            preds_in = preds_ff & ~(SetW'(1) << p_ff);
            state_in = ST_MEET;
         end
         ST_EMRD: begin
            d_ra = blk_ff;
            state_in = ST_EMSCAN;
            p_in = '0;
            found_in = 1'b0;
            idom_in = '0;
         end
         ST_EMSCAN: begin
            if (p_ff == '0 && !found_ff && idom_ff == '0) begin
               own_in = d_rd;
               idom_in = IdxW'(1);
            end else begin
               // Scan strict dominators in order; one set read each.
               if (!found_ff && strict[p_ff] && blk_ff != '0) begin
                  d_ra = p_ff;
                  state_in = ST_EMSCWT;
               end else if (found_ff || {1'b0, p_ff} == n_act - 6'd1 || blk_ff == '0) begin
                  state_in = ST_EMOUT;
               end else begin
                  p_in = p_ff + IdxW'(1);
               end
            end
         end
         ST_EMSCWT: begin
            if ((d_rd & strict) == strict) begin
               found_in = 1'b1;
               idom_in = p_ff;
               state_in = ST_EMOUT;
            end else if ({1'b0, p_ff} == n_act - 6'd1) begin
               state_in = ST_EMOUT;
            end else begin
               p_in = p_ff + IdxW'(1);
               state_in = ST_EMSCAN;
            end
         end
         ST_EMOUT: begin
            if (!rvalid_in) begin
               rvalid_in = 1'b1;
               rsp_in.block_id = blk_ff;
               rsp_in.dominator_mask = own_ff;
               rsp_in.idom_block = found_ff ? idom_ff : '0;
               rsp_in.idom_valid = found_ff;
               rsp_in.last = (blk_ff == last_blk);
               if (blk_ff == last_blk) begin
                  state_in = ST_IDLE;
               end else begin
                  blk_in = blk_ff + IdxW'(1);
                  state_in = ST_EMRD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // The emit scan enters with idom_ff as a first-cycle marker; clear it.
      if (state_ff == ST_EMSCAN && p_ff == '0 && !found_ff && idom_ff == '0) begin
         idom_in = '0;
         p_in = '0;
         state_in = ST_EMSCWT;
         d_ra = '0;
         if (!(d_rd[0] && blk_ff != '0)) begin
            state_in = ST_EMSCAN;
            idom_in = IdxW'(1);
         end
      end
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rvalid_ff <= 1'b0;
         changed_ff <= 1'b0;
         fwd_ff <= 1'b0;
         found_ff <= 1'b0;
         blk_ff <= '0;
         p_ff <= '0;
         idom_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rvalid_ff <= rvalid_in;
         changed_ff <= changed_in;
         fwd_ff <= fwd_in;
         found_ff <= found_in;
         blk_ff <= blk_in;
         p_ff <= p_in;
         idom_ff <= idom_in;
      end
      preds_ff <= preds_in;
      meet_ff <= meet_in;
      own_ff <= (state_ff == ST_PRDWT) ? (fwd_ff ? nxt : d_rd) : own_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_data = rsp_ff;

   // A stalled result beat stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && !rsp_ready |=> rvalid_ff && $stable(rsp_ff))
      else $error("result changed while stalled");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_entry_mask: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && rsp_ff.block_id == '0 |-> !rsp_ff.idom_valid)
      else $error("entry has an immediate dominator");
endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for cfg_dominator_sets: a directed table followed by random graphs, compared
// beat by beat with an in-bench dominator predictor or a typed result. Depends on cds_pkg.
`default_nettype none
module tb_top;
   import cds_pkg::*;

   localparam int LimitCycles = 3_000_000;
   localparam int SettleCycles = 80;
   localparam int RandomItems = 320;

   // One row of the directed table.
   typedef struct {
      bit      csr_set;
      int      csr_val;
      req_type item;
      bit      typed;
      rsp_type typed_rsp;
   } dir_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_wr_en;
   logic [5:0]        csr_wr_data;

   // Predictor state.
   logic [31:0]       pred_rows [32];
   logic [31:0]       dom_cur [32];
   int                block_count_q;
   rsp_type           dom_results_q [$];

   bit                typed_on;
   rsp_type           typed_rsp;
   bit                calm;
   bit                hold_req;
   int                hold_cnt;
   int                fail_cnt;
   int                items_sent;
   int                beats_checked;
   int                computes_seen;
   int                cycle_cnt;

   cfg_dominator_sets dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int active_blocks(int cnt);
      if (cnt < 1) return 1;
      if (cnt > MaxBlocks) return MaxBlocks;
      return cnt;
   endfunction

   function automatic logic [31:0] low_mask(int n);
      logic [32:0] one;
      one = 33'd1;
      return 32'((one << n) - 33'd1);
   endfunction

   // Run the dominator fixpoint and queue one beat per block.
   task automatic predict_compute();
      int n;
      logic [31:0] full, meet, nxt, strict;
      bit changed;
      rsp_type r;
      n = active_blocks(block_count_q);
      full = low_mask(n);
      dom_cur[0] = 32'd1;
      for (int b = 1; b < n; b++) dom_cur[b] = full;
      do begin
         changed = 0;
         for (int b = 1; b < n; b++) begin
            meet = full;
            for (int p = 0; p < n; p++)
               if (pred_rows[b][p]) meet &= dom_cur[p];
            nxt = meet | (32'd1 << b);
            if (nxt != dom_cur[b]) begin
               dom_cur[b] = nxt;
               changed = 1;
            end
         end
      end while (changed);
      for (int b = 0; b < n; b++) begin
         r = '0;
         r.block_id = 5'(b);
         r.dominator_mask = dom_cur[b];
         r.last = (b == n - 1);
         // The immediate dominator is the lowest strict dominator covering all others.
         strict = dom_cur[b] & ~(32'd1 << b) & full;
         if (b != 0) begin
            for (int d = 0; d < n; d++) begin
               if (strict[d] && ((dom_cur[d] & strict) == strict) && !r.idom_valid) begin
                  r.idom_block = 5'(d);
                  r.idom_valid = 1'b1;
               end
            end
         end
         dom_results_q = {dom_results_q, r};
      end
   endtask

   // Every accepted add, clear or compute beat updates the predictor.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         case (req_data.cmd)
            CMD_ADD: pred_rows[req_data.dst_block][req_data.src_block] = 1'b1;
            CMD_CLEAR: for (int i = 0; i < 32; i++) pred_rows[i] = '0;
            CMD_COMPUTE: begin
               computes_seen++;
               if (typed_on) begin
                  dom_results_q = {dom_results_q, typed_rsp};
               end else begin
                  predict_compute();
               end
            end
            default: ;
         endcase
      end
   end

   // Every accepted result beat is checked against the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (dom_results_q.size() == 0) begin
            $error("result beat for block %0d with nothing expected", rsp_data.block_id);
            fail_cnt++;
         end else begin
            e = dom_results_q.pop_front();
            beats_checked++;
            if (rsp_data.block_id !== e.block_id) begin
               $error("block_id: expected %0d, got %0d", e.block_id, rsp_data.block_id);
               fail_cnt++;
            end
            if (rsp_data.dominator_mask !== e.dominator_mask) begin
               $error("dominator_mask: expected %h, got %h", e.dominator_mask,
                      rsp_data.dominator_mask);
               fail_cnt++;
            end
            if (rsp_data.idom_block !== e.idom_block) begin
               $error("idom_block: expected %0d, got %0d", e.idom_block, rsp_data.idom_block);
               fail_cnt++;
            end
            if (rsp_data.idom_valid !== e.idom_valid) begin
               $error("idom_valid: expected %0b, got %0b", e.idom_valid, rsp_data.idom_valid);
               fail_cnt++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last: expected %0b, got %0b", e.last, rsp_data.last);
               fail_cnt++;
            end
         end
      end
   end

   // Receiver: random stalls, a long hold-off on request, none while calm.
   initial begin
      rsp_ready = 1'b0;
      hold_cnt = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            hold_cnt = 600;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 17);
         end
      end
   end

   // Watchdog.
   initial begin
      cycle_cnt = 0;
      forever begin
         @(posedge clock);
         cycle_cnt++;
         if (cycle_cnt >= LimitCycles) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Offer one request beat and hold it until it is accepted.
   task automatic send_item(req_type item, bit typed = 0, rsp_type tr = '0);
      while (!calm && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      typed_on = typed;
      typed_rsp = tr;
      req_data <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      items_sent++;
      @(negedge clock);
   endtask

   // Pause the sender until all results are in and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (dom_results_q.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_count(int v);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= 6'(v);
      block_count_q = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_type mk(cmd_type c, int s, int d);
      req_type r;
      r.cmd = c;
      r.src_block = 5'(s);
      r.dst_block = 5'(d);
      return r;
   endfunction

   function automatic dir_row_type row(int csr, cmd_type c, int s, int d, bit typed = 0);
      dir_row_type r;
      r.csr_set = (csr >= 0);
      r.csr_val = csr;
      r.item = mk(c, s, d);
      r.typed = typed;
      // The only typed result: a single entry block, dominated by itself alone.
      r.typed_rsp = '{block_id: 5'd0, dominator_mask: 32'd1, idom_block: 5'd0,
                      idom_valid: 1'b0, last: 1'b1};
      return r;
   endfunction

   initial begin
      dir_row_type dir_rows [$];
      int n, k, r, s, d;
      req_type it;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      calm = 0;
      hold_req = 0;
      typed_on = 0;
      fail_cnt = 0;
      items_sent = 0;
      beats_checked = 0;
      computes_seen = 0;
      block_count_q = 1;
      for (int i = 0; i < 32; i++) begin
         pred_rows[i] = '0;
         dom_cur[i] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: reset count, zero count, a diamond, entry edges, clamped count.
      dir_rows = {
         row(-1, CMD_COMPUTE, 0, 0, 1),
         row(-1, CMD_NONE, 31, 31),
         row(0, CMD_COMPUTE, 0, 0, 1),
         row(4, CMD_ADD, 0, 1),
         row(-1, CMD_ADD, 0, 2),
         row(-1, CMD_ADD, 1, 3),
         row(-1, CMD_ADD, 2, 3),
         row(-1, CMD_ADD, 3, 0),
         row(-1, CMD_COMPUTE, 0, 0),
         row(-1, CMD_ADD, 31, 31),
         row(-1, CMD_ADD, 31, 1),
         row(-1, CMD_COMPUTE, 0, 0),
         row(-1, CMD_CLEAR, 0, 0),
         row(-1, CMD_COMPUTE, 0, 0),
         row(63, CMD_ADD, 0, 31),
         row(-1, CMD_ADD, 31, 30),
         row(-1, CMD_ADD, 30, 1),
         row(-1, CMD_ADD, 1, 0),
         row(-1, CMD_COMPUTE, 0, 0),
         row(32, CMD_ADD, 0, 16),
         row(-1, CMD_ADD, 16, 31),
         row(-1, CMD_COMPUTE, 0, 0),
         row(-1, CMD_CLEAR, 0, 0)
      };
      foreach (dir_rows[i]) begin
         if (dir_rows[i].csr_set) write_count(dir_rows[i].csr_val);
         send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].typed_rsp);
      end

      // Random part: each phase sets a count, builds a graph and computes it.
      for (int phase = 0; items_sent < RandomItems; phase++) begin
         r = $urandom_range(99);
         if (r < 10) k = 32;
         else if (r < 15) k = $urandom_range(33, 63);
         else if (r < 18) k = 0;
         else k = $urandom_range(1, 8);
         write_count(k);
         calm = (phase >= 3 && phase < 6);
         n = active_blocks(k);
         if ($urandom_range(3) == 0) send_item(mk(CMD_CLEAR, 0, 0));
         k = $urandom_range(0, (2 * n > 40) ? 40 : 2 * n);
         for (int e = 0; e < k; e++) begin
            r = $urandom_range(99);
            if (r < 5) it = mk(CMD_NONE, $urandom_range(31), $urandom_range(31));
            else if (r < 12) it = mk(CMD_ADD, $urandom_range(31), $urandom_range(31));
            else begin
               s = $urandom_range(n - 1);
               d = $urandom_range(n - 1);
               it = mk(CMD_ADD, s, d);
            end
            send_item(it);
         end
         // One phase stalls the receiver long enough to back up the request side.
         if (phase == 7) hold_req = 1;
         send_item(mk(CMD_COMPUTE, 0, 0));
         if (phase == 7)
            for (int e = 0; e < 6; e++)
               send_item(mk(CMD_ADD, $urandom_range(31), $urandom_range(31)));
      end

      req_valid <= 1'b0;
      calm = 0;
      while (dom_results_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);

      $display("Sent %0d request beats including %0d computes; checked %0d result beats.",
               items_sent, computes_seen, beats_checked);
      if (fail_cnt == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: cfg_dominator_sets.f
sv/cds_pkg.sv
sv/cds_ram.sv
sv/cfg_dominator_sets.sv
dv/tb_top.sv
